>>> design/ptb_pkg.sv
// Shared types and constants of the three-level page table builder.
`timescale 1ns / 1ps

package ptb_pkg;

    // Counts hold up to 127, above the default entry limit (64).
    localparam int CNT_W     = 7;
    localparam int TOP_IDX_W = 25;
    localparam int LOW_IDX_W = 9;
    localparam int BLK_W     = 43;

    localparam int SHIFT_L1 = 39;
    localparam int SHIFT_L2 = 30;
    localparam int SHIFT_L3 = 21;

    localparam logic [63:0] TABLE_TYPE = 64'd3;

    localparam logic [1:0] CFG_TABLE_BASE  = 2'd0;
    localparam logic [1:0] CFG_BLOCK_FLAGS = 2'd1;
    localparam logic [1:0] CFG_TOP_ORDER   = 2'd2;

    localparam logic [11:0] BLOCK_FLAGS_RESET = 12'h781;
    localparam logic [4:0]  TOP_ORDER_RESET   = 5'd9;

    localparam logic [1:0] LEVEL_NONE  = 2'd0;
    localparam logic [1:0] LEVEL_TOP   = 2'd1;
    localparam logic [1:0] LEVEL_MID   = 2'd2;
    localparam logic [1:0] LEVEL_BLOCK = 2'd3;

    typedef struct packed {
        logic [63:0] table_base;
        logic [11:0] block_flags;
        logic [4:0]  top_order;
    } ptb_cfg_t;

    typedef struct packed {
        logic                 overflow;
        logic [TOP_IDX_W-1:0] is0;
        logic [LOW_IDX_W-1:0] is1;
        logic [LOW_IDX_W-1:0] is2;
        logic [CNT_W-1:0]     num0;
        logic [CNT_W-1:0]     num1;
        logic [CNT_W-1:0]     num2;
        logic [BLK_W-1:0]     blk;
    } ptb_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ptb_qstat_t;

endpackage

>>> design/ptb_req_if.sv
// Request channel: virtual range and physical start of one mapping.
`timescale 1ns / 1ps

interface ptb_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] virt_start;
    logic [63:0] virt_end;
    logic [63:0] phys_start;

    modport source (output valid, output virt_start, output virt_end, output phys_start,
                    input ready);
    modport sink (input valid, input virt_start, input virt_end, input phys_start,
                  output ready);
endinterface

>>> design/ptb_ent_if.sv
// Entry channel: one page table entry or an overflow marker per transfer.
`timescale 1ns / 1ps

interface ptb_ent_if;
    logic        valid;
    logic        ready;
    logic [63:0] entry_address;
    logic [63:0] entry_value;
    logic [1:0]  level;
    logic        overflow;
    logic        last;

    modport source (output valid, output entry_address, output entry_value, output level,
                    output overflow, output last, input ready);
    modport sink (input valid, input entry_address, input entry_value, input level,
                  input overflow, input last, output ready);
endinterface

>>> design/ptb_front.sv
// Front end: takes a request and plans index ranges and counts per level.
`timescale 1ns / 1ps

module ptb_front #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    ptb_req_if.sink             req,
    input  logic [4:0]          top_order,
    input  ptb_pkg::ptb_qstat_t qstat,
    output logic                push,
    output ptb_pkg::ptb_desc_t  desc
);
    import ptb_pkg::*;

    localparam int TOT_W = CNT_W + 2;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_IDX  = 5'b00010,
        F_DIF  = 5'b00100,
        F_SUM  = 5'b01000,
        F_PUSH = 5'b10000
    } front_state_t;

    front_state_t         state_reg, state_next;
    logic [1:0]           lv_reg, lv_next;
    logic                 ovf_reg, ovf_next;
    logic [63:0]          vs_reg, vs_next;
    logic [63:0]          ve_reg, ve_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [63:0]          ie_reg, ie_next;
    logic [63:0]          scale_reg, scale_next;
    logic [TOP_IDX_W-1:0] is_reg [3];
    logic [TOP_IDX_W-1:0] is_next [3];
    logic [CNT_W-1:0]     num_reg [3];
    logic [CNT_W-1:0]     num_next [3];

    logic [TOP_IDX_W-1:0] top_mask;
    logic [63:0]          is_wide;
    logic [63:0]          diff;
    logic [TOT_W-1:0]     total;
    logic                 accept;

    always_comb
    begin
        for (int b = 0; b < TOP_IDX_W; b++)
        begin
            top_mask[b] = (5'(b) < top_order);
        end
    end

    assign req.ready = (state_reg == F_IDLE);
    assign accept    = req.valid && req.ready;
    assign push      = (state_reg == F_PUSH) && !qstat.full;
    assign is_wide   = 64'(is_reg[lv_reg]);
    assign diff      = ie_reg - is_wide;
    assign total     = TOT_W'(num_reg[0]) + TOT_W'(num_reg[1]) + TOT_W'(num_reg[2]);

    always_comb
    begin
        desc.overflow = ovf_reg;
        desc.is0      = is_reg[0];
        desc.is1      = is_reg[1][LOW_IDX_W-1:0];
        desc.is2      = is_reg[2][LOW_IDX_W-1:0];
        desc.num0     = num_reg[0];
        desc.num1     = num_reg[1];
        desc.num2     = num_reg[2];
        desc.blk      = blk_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        lv_next    = lv_reg;
        ovf_next   = ovf_reg;
        vs_next    = vs_reg;
        ve_next    = ve_reg;
        blk_next   = blk_reg;
        ie_next    = ie_reg;
        scale_next = scale_reg;
        is_next    = is_reg;
        num_next   = num_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    vs_next    = req.virt_start;
                    ve_next    = req.virt_end - 64'd1;
                    blk_next   = req.phys_start[63:SHIFT_L3];
                    lv_next    = 2'd0;
                    ovf_next   = 1'b0;
                    scale_next = 64'd0;
                    state_next = F_IDX;
                end
            end
            F_IDX:
            begin
                // Below the top level, the end index is raised by the extra entries of the level above.
                case (lv_reg)
                    2'd0:
                    begin
                        is_next[0] = vs_reg[63:SHIFT_L1] & top_mask;
                        ie_next    = 64'(ve_reg[63:SHIFT_L1] & top_mask);
                    end
                    2'd1:
                    begin
                        is_next[1] = TOP_IDX_W'(vs_reg[SHIFT_L1-1:SHIFT_L2]);
                        ie_next    = 64'(ve_reg[SHIFT_L1-1:SHIFT_L2])
                                   + {scale_reg[63-LOW_IDX_W:0], {LOW_IDX_W{1'b0}}};
                    end
                    default:
                    begin
                        is_next[2] = TOP_IDX_W'(vs_reg[SHIFT_L2-1:SHIFT_L3]);
                        ie_next    = 64'(ve_reg[SHIFT_L2-1:SHIFT_L3])
                                   + {scale_reg[63-LOW_IDX_W:0], {LOW_IDX_W{1'b0}}};
                    end
                endcase
                state_next = F_DIF;
            end
            F_DIF:
            begin
                scale_next = diff;
                if (ie_reg >= is_wide)
                begin
                    num_next[lv_reg] = diff[CNT_W-1:0] + CNT_W'(1);
                end
                else
                begin
                    // Reversed range writes a single entry.
                    num_next[lv_reg] = CNT_W'(1);
                end
                if ((ie_reg >= is_wide) && (diff >= 64'(MAX_ENTRIES)))
                begin
                    ovf_next   = 1'b1;
                    state_next = F_PUSH;
                end
                else if (lv_reg == 2'd2)
                begin
                    state_next = F_SUM;
                end
                else
                begin
                    lv_next    = lv_reg + 2'd1;
                    state_next = F_IDX;
                end
            end
            F_SUM:
            begin
                if (total > TOT_W'(MAX_ENTRIES))
                begin
                    ovf_next = 1'b1;
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!qstat.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            lv_reg    <= 2'd0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lv_reg    <= lv_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vs_reg    <= vs_next;
        ve_reg    <= ve_next;
        blk_reg   <= blk_next;
        ie_reg    <= ie_next;
        scale_reg <= scale_next;
        is_reg    <= is_next;
        num_reg   <= num_next;
    end

endmodule

>>> design/ptb_queue.sv
// Two-entry queue of planned requests between front and back end.
`timescale 1ns / 1ps

module ptb_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ptb_pkg::ptb_desc_t  wdata,
    input  logic                pop,
    output ptb_pkg::ptb_desc_t  rdata,
    output ptb_pkg::ptb_qstat_t qstat
);
    import ptb_pkg::*;

    ptb_desc_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign rdata       = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> design/ptb_back.sv
// Back end: walks a planned request and emits its entries one per cycle while the receiver accepts them.
`timescale 1ns / 1ps

module ptb_back #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ptb_pkg::ptb_cfg_t   cfg,
    input  ptb_pkg::ptb_desc_t  desc,
    input  ptb_pkg::ptb_qstat_t qstat,
    output logic                pop,
    ptb_ent_if.source           ent
);
    import ptb_pkg::*;

    localparam logic [63:0] PAGE_STEP = 64'(PAGE_BYTES);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [1:0]           lvl_reg, lvl_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic [63:0]          addr_reg, addr_next;
    logic [63:0]          next_reg, next_next;
    logic [63:0]          sv_reg, sv_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [LOW_IDX_W-1:0] is1_reg, is1_next;
    logic [LOW_IDX_W-1:0] is2_reg, is2_next;
    logic [CNT_W-1:0]     num1_reg, num1_next;
    logic [CNT_W-1:0]     num2_reg, num2_next;

    logic                 o_valid_reg, o_valid_next;
    logic [63:0]          o_addr_reg, o_addr_next;
    logic [63:0]          o_val_reg, o_val_next;
    logic [1:0]           o_level_reg, o_level_next;
    logic                 o_ovf_reg, o_ovf_next;
    logic                 o_last_reg, o_last_next;

    logic                 slot_free;
    logic                 level_done;

    assign ent.valid         = o_valid_reg;
    assign ent.entry_address = o_addr_reg;
    assign ent.entry_value   = o_val_reg;
    assign ent.level         = o_level_reg;
    assign ent.overflow      = o_ovf_reg;
    assign ent.last          = o_last_reg;

    assign slot_free  = !o_valid_reg || ent.ready;
    assign pop        = (state_reg == B_IDLE) && !qstat.empty;
    assign level_done = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        addr_next    = addr_reg;
        next_next    = next_reg;
        sv_next      = sv_reg;
        blk_next     = blk_reg;
        is1_next     = is1_reg;
        is2_next     = is2_reg;
        num1_next    = num1_reg;
        num2_next    = num2_reg;
        o_valid_next = ent.ready ? 1'b0 : o_valid_reg;
        o_addr_next  = o_addr_reg;
        o_val_next   = o_val_reg;
        o_level_next = o_level_reg;
        o_ovf_next   = o_ovf_reg;
        o_last_next  = o_last_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    addr_next  = cfg.table_base + {36'd0, desc.is0, 3'b000};
                    next_next  = cfg.table_base + PAGE_STEP;
                    sv_next    = cfg.table_base + PAGE_STEP;
                    lvl_next   = LEVEL_TOP;
                    cnt_next   = desc.num0;
                    ovf_next   = desc.overflow;
                    blk_next   = desc.blk;
                    is1_next   = desc.is1;
                    is2_next   = desc.is2;
                    num1_next  = desc.num1;
                    num2_next  = desc.num2;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (slot_free)
                begin
                    o_valid_next = 1'b1;
                    if (ovf_reg)
                    begin
                        o_addr_next  = 64'd0;
                        o_val_next   = 64'd0;
                        o_level_next = LEVEL_NONE;
                        o_ovf_next   = 1'b1;
                        o_last_next  = 1'b1;
                        state_next   = B_IDLE;
                    end
                    else
                    begin
                        o_addr_next  = addr_reg;
                        o_level_next = lvl_reg;
                        o_ovf_next   = 1'b0;
                        o_last_next  = 1'b0;
                        addr_next    = addr_reg + 64'd8;
                        cnt_next     = cnt_reg - CNT_W'(1);
                        case (lvl_reg)
                            LEVEL_TOP:
                            begin
                                o_val_next = next_reg | TABLE_TYPE;
                                next_next  = next_reg + PAGE_STEP;
                                if (level_done)
                                begin
                                    // Level 2 tables start at the first page after the top table.
                                    addr_next = sv_reg + {52'd0, is1_reg, 3'b000};
                                    sv_next   = next_reg + PAGE_STEP;
                                    cnt_next  = num1_reg;
                                    lvl_next  = LEVEL_MID;
                                end
                            end
                            LEVEL_MID:
                            begin
                                o_val_next = next_reg | TABLE_TYPE;
                                next_next  = next_reg + PAGE_STEP;
                                if (level_done)
                                begin
                                    addr_next = sv_reg + {52'd0, is2_reg, 3'b000};
                                    cnt_next  = num2_reg;
                                    lvl_next  = LEVEL_BLOCK;
                                end
                            end
                            default:
                            begin
                                o_val_next  = {blk_reg, 9'd0, cfg.block_flags};
                                blk_next    = blk_reg + BLK_W'(1);
                                o_last_next = level_done;
                                if (level_done)
                                begin
                                    state_next = B_IDLE;
                                end
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            o_valid_reg <= 1'b0;
            lvl_reg     <= LEVEL_NONE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            o_valid_reg <= o_valid_next;
            lvl_reg     <= lvl_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        next_reg    <= next_next;
        sv_reg      <= sv_next;
        blk_reg     <= blk_next;
        is1_reg     <= is1_next;
        is2_reg     <= is2_next;
        num1_reg    <= num1_next;
        num2_reg    <= num2_next;
        o_addr_reg  <= o_addr_next;
        o_val_reg   <= o_val_next;
        o_level_reg <= o_level_next;
        o_ovf_reg   <= o_ovf_next;
        o_last_reg  <= o_last_next;
    end

endmodule

>>> design/three_level_page_table_builder.sv
// Three-level page table builder: request in, page table entries out.
// Channel req carries one mapping (virt_start, exclusive virt_end, phys_start).
// Channel ent returns the entries it needs, level 1 first, in index order;
// the final entry of a request has last set. A request needing more than
// MAX_ENTRIES entries yields one result with overflow and last set instead.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 table_base,
// 1 block_flags, 2 top_order); write only while no request is in flight.
// Per level the front end plans in an index step and a difference step,
// then sums the counts and pushes the plan, stopping early on overflow.
// The back end loads the plan and emits n entries at one per cycle through
// its output register while the receiver accepts them. A two-entry queue
// lets planning overlap emission.
// Reset clears the control state; configuration returns to table_base 0,
// block_flags 0x781, top_order 9. A stalled receiver holds the output
// register; the back end then stops, the queue fills and req.ready drops.
`timescale 1ns / 1ps

module three_level_page_table_builder #(
    parameter int MAX_ENTRIES = 64,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    ptb_req_if.sink     req,
    ptb_ent_if.source   ent,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import ptb_pkg::*;

    ptb_cfg_t   cfg_reg, cfg_next;
    ptb_desc_t  push_desc;
    ptb_desc_t  pop_desc;
    ptb_qstat_t qstat;
    logic       push;
    logic       pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TABLE_BASE:  cfg_next.table_base  = cfg_data;
                CFG_BLOCK_FLAGS: cfg_next.block_flags = cfg_data[11:0];
                CFG_TOP_ORDER:   cfg_next.top_order   = cfg_data[4:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_base  <= 64'd0;
            cfg_reg.block_flags <= BLOCK_FLAGS_RESET;
            cfg_reg.top_order   <= TOP_ORDER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ptb_front #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .top_order(cfg_reg.top_order),
        .qstat    (qstat),
        .push     (push),
        .desc     (push_desc)
    );

    ptb_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata(push_desc),
        .pop  (pop),
        .rdata(pop_desc),
        .qstat(qstat)
    );

    ptb_back #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_back (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_reg),
        .desc (pop_desc),
        .qstat(qstat),
        .pop  (pop),
        .ent  (ent)
    );

`ifndef ASSERT_OFF
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("planned request pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("back end popped an empty queue");

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty together");

    a_overflow_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (ent.valid && ent.overflow) |-> (ent.last && (ent.level == LEVEL_NONE)))
        else $error("overflow result without last or with a level");
`endif

endmodule

>>> test/tb.sv
// Self-checking testbench for the three-level page table builder.
`timescale 1ns / 1ps

module tb;
    import ptb_pkg::*;

    localparam int MAX_ENTRIES = 64;
    localparam logic [63:0] PAGE_BYTES = 64'd4096;
    localparam logic [63:0] BLOCK_SIZE = 64'h20_0000;

    typedef struct packed {
        logic [63:0] addr;
        logic [63:0] value;
        logic [1:0]  level;
        logic        overflow;
        logic        last;
    } map_entry_t;

    class entry_board;
        logic [63:0] table_base;
        logic [11:0] block_flags;
        logic [4:0]  top_order;
        map_entry_t  pending[$];
        int          errors;

        function new();
            table_base  = '0;
            block_flags = BLOCK_FLAGS_RESET;
            top_order   = TOP_ORDER_RESET;
            errors      = 0;
        endfunction

        // Plan the three levels, then queue the entries they produce.
        function void note_request(logic [63:0] vs, logic [63:0] vend, logic [63:0] ps);
            logic [63:0] ve, scale, mask, first, stop, tbl, nxt, saved, blk;
            logic [63:0] lv_first[3];
            int          lv_count[3];
            int          sh, ord;
            bit          fits;
            map_entry_t  e;
            ve    = vend - 64'd1;
            scale = '0;
            fits  = 1'b1;
            for (int lv = 0; lv < 3 && fits; lv++) begin
                sh    = (lv == 0) ? SHIFT_L1 : (lv == 1) ? SHIFT_L2 : SHIFT_L3;
                ord   = (lv == 0) ? int'(top_order) : LOW_IDX_W;
                mask  = (64'd1 << ord) - 64'd1;
                first = (vs >> sh) & mask;
                stop  = ((ve >> sh) & mask) + (scale << ord);
                // hand the wrapped span down as the next level's scale
                scale = stop - first;
                lv_first[lv] = first;
                if (stop >= first) begin
                    if (stop - first >= 64'(MAX_ENTRIES))
                        fits = 1'b0;
                    else
                        lv_count[lv] = int'(stop - first) + 1;
                end
                else begin
                    lv_count[lv] = 1;
                end
            end
            if (fits && lv_count[0] + lv_count[1] + lv_count[2] > MAX_ENTRIES)
                fits = 1'b0;
            if (!fits) begin
                e = '{addr: '0, value: '0, level: LEVEL_NONE, overflow: 1'b1, last: 1'b1};
                pending.push_back(e);
                return;
            end
            tbl = table_base;
            nxt = table_base + PAGE_BYTES;
            for (int lv = 0; lv < 2; lv++) begin
                saved = nxt;
                for (int i = 0; i < lv_count[lv]; i++) begin
                    e.addr     = tbl + ((lv_first[lv] + 64'(i)) << 3);
                    e.value    = nxt | TABLE_TYPE;
                    e.level    = (lv == 0) ? LEVEL_TOP : LEVEL_MID;
                    e.overflow = 1'b0;
                    e.last     = 1'b0;
                    pending.push_back(e);
                    nxt += PAGE_BYTES;
                end
                tbl = saved;
            end
            blk = ps & ~(BLOCK_SIZE - 64'd1);
            for (int i = 0; i < lv_count[2]; i++) begin
                e.addr     = tbl + ((lv_first[2] + 64'(i)) << 3);
                e.value    = blk | {52'd0, block_flags};
                e.level    = LEVEL_BLOCK;
                e.overflow = 1'b0;
                e.last     = 1'b0;
                pending.push_back(e);
                blk += BLOCK_SIZE;
            end
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_entry(map_entry_t got);
            map_entry_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected entry addr %h value %h level %0d ovf %b last %b",
                             $realtime, got.addr, got.value, got.level, got.overflow, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.addr !== want.addr || got.value !== want.value || got.level !== want.level
                || got.overflow !== want.overflow || got.last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch expected addr %h value %h level %0d ovf %b last %b,",
                             $realtime, want.addr, want.value, want.level, want.overflow,
                             want.last, " got addr %h value %h level %0d ovf %b last %b",
                             got.addr, got.value, got.level, got.overflow, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    bit          calm;
    entry_board  board;

    ptb_req_if req_ch();
    ptb_ent_if ent_ch();

    three_level_page_table_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .ent       (ent_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Receiver: random back-pressure unless calm is set, and check every transfer on the entry channel.
    always @(posedge clk)
    begin
        if (rst_n && ent_ch.valid && ent_ch.ready)
            board.check_entry('{addr: ent_ch.entry_address, value: ent_ch.entry_value,
                                level: ent_ch.level, overflow: ent_ch.overflow,
                                last: ent_ch.last});
        ent_ch.ready <= rst_n && (calm || $urandom_range(99) >= 21);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_TABLE_BASE:  board.table_base  = data;
            CFG_BLOCK_FLAGS: board.block_flags = data[11:0];
            CFG_TOP_ORDER:   board.top_order   = data[4:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] base, input logic [11:0] flags,
                             input logic [4:0] order);
        write_reg(CFG_TABLE_BASE, base);
        write_reg(CFG_BLOCK_FLAGS, {52'd0, flags});
        write_reg(CFG_TOP_ORDER, {59'd0, order});
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic [63:0] vs, input logic [63:0] vend,
                                input logic [63:0] ps);
        while (!calm && $urandom_range(99) < 21)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.virt_start <= vs;
        req_ch.virt_end   <= vend;
        req_ch.phys_start <= ps;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(vs, vend, ps);
    endtask

    // Mostly block runs, often near level boundaries; some oversized, some arbitrary ends.
    task automatic send_random_request();
        logic [63:0] vs, vend, ps;
        int          kind, nblk;
        vs   = {$urandom, $urandom};
        ps   = {$urandom, $urandom};
        kind = $urandom_range(99);
        case ($urandom_range(3))
            0: vs[29:21] = 9'h1FF - 9'($urandom_range(3));
            1: vs[38:21] = 18'h3FFFF - 18'($urandom_range(3));
            2: vs[20:0]  = '0;
            default: ;
        endcase
        if (kind < 70 || kind < 85) begin
            nblk = (kind < 70) ? $urandom_range(1, 40) : $urandom_range(41, 80);
            vend = vs + 64'(nblk) * BLOCK_SIZE - 64'($urandom_range(0, 32'h1F_FFFF));
        end
        else if (kind < 95)
            vend = {$urandom, $urandom};
        else
            vend = $urandom_range(1) ? vs : 64'd0;
        send_request(vs, vend, ps);
    endtask

    // Hold off until every expected entry is back and the pipeline has drained.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_random_request();
        wait_idle();
    endtask

    initial
    begin
        board             = new();
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_TABLE_BASE;
        cfg_data          = '0;
        calm              = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.virt_start = '0;
        req_ch.virt_end   = '0;
        req_ch.phys_start = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration
        send_request(64'd0, BLOCK_SIZE, 64'd0);
        send_request(64'd0, 64'd0, 64'd0);
        send_request('1, '1, '1);
        send_request('1, 64'd0, 64'd0);
        send_request(64'd0, 64'd62 * BLOCK_SIZE, 64'h1234_5678_9ABC_DEF0);
        send_request(64'd0, 64'd63 * BLOCK_SIZE, 64'd0);
        send_request(64'd0, 64'd65 * BLOCK_SIZE, 64'd0);
        send_request(64'h40_0000, 64'h20_0000, 64'd0);
        send_request(64'h4000_0000, 64'h4000_0000, 64'd0);
        send_request(64'h3FE0_0000, 64'h4020_0000, 64'h0001_2345_6789_ABCD);
        send_request((64'd1 << 39) - BLOCK_SIZE, (64'd1 << 39) + BLOCK_SIZE, 64'd0);
        send_request(64'h0123_4567_89AB_CDEF, 64'h0123_4567_89EB_CDEF,
                     64'hFFFF_FFFF_FFE0_0000);
        send_request(64'h8000_0000_0000_0000, 64'h8000_0000_0060_0000, 64'h5555_5555_5555_5555);
        send_request(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_idle();

        configure({$urandom, $urandom_range(0, 32'hFFFF_FFFF) & 32'hFFFF_F000},
                  12'($urandom_range(0, 4095)), 5'd1);
        random_phase(70);

        // no idling on either side here
        calm = 1'b1;
        configure(64'hFFFF_FFFF_FFFF_F000, 12'hFFF, 5'd16);
        random_phase(70);
        calm = 1'b0;

        configure(64'd0, 12'h000, 5'd0);
        random_phase(70);

        configure({$urandom, $urandom}, 12'($urandom_range(0, 4095)), 5'd31);
        random_phase(70);

        configure({$urandom, $urandom & 32'hFFFF_F000}, BLOCK_FLAGS_RESET, TOP_ORDER_RESET);
        random_phase(70);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
design/ptb_pkg.sv
design/ptb_req_if.sv
design/ptb_ent_if.sv
design/ptb_front.sv
design/ptb_queue.sv
design/ptb_back.sv
design/three_level_page_table_builder.sv
test/tb.sv
